@@ rtl/sha256_stream_hasher_defines.svh @@
// Assertion macros shared by the SHA-256 stream hasher RTL.
// No dependencies; included by sha_ctrl, the module that carries assertions.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sha_pkg.sv @@
// Shared types, codes and constant tables for the SHA-256 stream hasher.
// No dependencies; used by sha_dp, sha_ctrl and sha256_stream_hasher.
`default_nettype none

package sha_pkg;

    // Source of the byte written into the block line.
    typedef logic [1:0] t_byte_kind;
    localparam t_byte_kind BYTE_DATA = 2'd0;
    localparam t_byte_kind BYTE_80   = 2'd1;
    localparam t_byte_kind BYTE_ZERO = 2'd2;
    localparam t_byte_kind BYTE_LEN  = 2'd3;

    localparam int unsigned DIGEST_WORDS = 8;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd7;

    // Commands from the controller to the datapath and output stage.
    typedef struct packed {
        logic       wr_byte;
        t_byte_kind byte_kind;
        logic       count_inc;
        logic       start;
        logic       round;
        logic       fold;
        logic       init;
        logic       load_out;
        logic [2:0] word_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_last;
        logic pos_56;
        logic round_last;
    } t_sts;

    function automatic logic [31:0] f_init_h(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] f_round_k(input logic [5:0] idx);
        logic [31:0] v;
        case (idx)
            6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
            6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
            6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
            6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
            6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
            6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
            6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
            6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
            6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
            6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
            6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
            6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
            6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
            6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
            6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
            6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
            6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
            6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
            6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
            6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
            6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
            6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
            6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
            6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
            6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
            6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
            6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
            6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
            6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
            6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
            6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
            6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: controller, datapath and the
// registered result stage. Depends on sha_pkg, sha_ctrl and sha_dp.
//
//  Channel   | Direction | tdata            | tuser          | tlast
//  ----------+-----------+------------------+----------------+----------------
//  s_axis    | in        | data_byte [7:0]  | has_byte [0]   | end_of_message
//  m_axis    | out       | digest_word[31:0]| word_index[2:0]| last_word
//
// A transaction carrying a byte writes it into the block line; the byte that fills a 64-byte
// block also starts a compression: 64 rounds of the single round unit plus one fold.
// A closing transaction writes the padding through the same block line,
// compresses one or two blocks, then emits the eight digest words, one per
// cycle while m_axis_tready is high.
// Reset is synchronous and active low; it loads the initial hash values and
// clears the byte count. A stall on m_axis only holds the result register and
// the digest sequencing; s_axis_tready is high only while the block is idle,
// and a new message may start while the last digest word still waits.
`default_nettype none

module sha256_stream_hasher (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] has_byte
    input  wire logic        i_s_axis_tlast,   // end_of_message
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]       o_m_axis_tuser,   // [2:0] word_index
    output logic             o_m_axis_tlast    // last_word
);

    sha_pkg::t_cmd cmd;
    sha_pkg::t_sts sts;
    logic [31:0]   hash_word;
    logic          out_free;

    // Result register: valid until the downstream side takes it.
    logic          r_out_valid;
    logic [31:0]   r_out_word;
    logic [2:0]    r_out_idx;
    logic          r_out_last;

    assign out_free = !r_out_valid || i_m_axis_tready;

    sha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_has_byte (i_s_axis_tuser),
        .i_end_msg  (i_s_axis_tlast),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    sha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_data_byte (i_s_axis_tdata),
        .o_sts       (sts),
        .o_hash_word (hash_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload only changes when a new digest word is loaded.
    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_out_word <= hash_word;
            r_out_idx  <= cmd.word_idx;
            r_out_last <= (cmd.word_idx == sha_pkg::LAST_WORD_IDX);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_word;
    assign o_m_axis_tuser  = r_out_idx;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/sha_dp.sv @@
// Datapath of the SHA-256 stream hasher: block line, message schedule,
// round unit, chaining words and byte count. Depends on sha_pkg.
`default_nettype none

module sha_dp (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    input  wire logic [7:0]   i_data_byte,
    output sha_pkg::t_sts     o_sts,
    output logic [31:0]       o_hash_word
);

    // The block line holds 64 bytes; word 0 is the top 32 bits. Bytes shift
    // in at the bottom, and during rounds it acts as the 16-word schedule.
    logic [511:0] r_line;
    logic [5:0]   r_pos;
    logic [60:0]  r_count;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [5:0]   r_rnd;

    logic [63:0]  len_bits;
    logic [7:0]   wr_byte;
    logic [31:0]  w0, w1, w9, w14, new_w;
    logic [31:0]  t1, t2, ch, maj;

    function automatic logic [31:0] f_ssig0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
    endfunction

    function automatic logic [31:0] f_ssig1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
    endfunction

    function automatic logic [31:0] f_bsig0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] f_bsig1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    assign len_bits = {r_count, 3'b000};

    always_comb begin
        case (i_cmd.byte_kind)
            sha_pkg::BYTE_DATA: wr_byte = i_data_byte;
            sha_pkg::BYTE_80:   wr_byte = 8'h80;
            sha_pkg::BYTE_ZERO: wr_byte = 8'h00;
            sha_pkg::BYTE_LEN:  wr_byte = len_bits[{~r_pos[2:0], 3'b000} +: 8];
            default:            wr_byte = 8'h00;
        endcase
    end

    // Schedule taps: w[t], w[t+1], w[t+9] and w[t+14].
    assign w0    = r_line[511:480];
    assign w1    = r_line[479:448];
    assign w9    = r_line[223:192];
    assign w14   = r_line[63:32];
    assign new_w = f_ssig1(w14) + w9 + f_ssig0(w1) + w0;

    assign ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t1  = r_v[7] + f_bsig1(r_v[4]) + ch + sha_pkg::f_round_k(r_rnd) + w0;
    assign t2  = f_bsig0(r_v[0]) + maj;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_byte) begin
            r_line <= {r_line[503:0], wr_byte};
        end else if (i_cmd.round) begin
            r_line <= {r_line[479:0], new_w};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end else if (i_cmd.round) begin
            r_v[0] <= t1 + t2;
            r_v[1] <= r_v[0];
            r_v[2] <= r_v[1];
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3] + t1;
            r_v[5] <= r_v[4];
            r_v[6] <= r_v[5];
            r_v[7] <= r_v[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_rnd   <= '0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::f_init_h(3'(i));
            end
        end else begin
            if (i_cmd.wr_byte) begin
                r_pos <= r_pos + 6'd1;
            end
            if (i_cmd.init) begin
                r_count <= '0;
            end else if (i_cmd.count_inc) begin
                r_count <= r_count + 61'd1;
            end
            if (i_cmd.start) begin
                r_rnd <= '0;
            end else if (i_cmd.round) begin
                r_rnd <= r_rnd + 6'd1;
            end
            for (int i = 0; i < 8; i++) begin
                if (i_cmd.init) begin
                    r_h[i] <= sha_pkg::f_init_h(3'(i));
                end else if (i_cmd.fold) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end
        end
    end

    assign o_sts.pos_last   = (r_pos == 6'd63);
    assign o_sts.pos_56     = (r_pos == 6'd56);
    assign o_sts.round_last = (r_rnd == 6'd63);
    assign o_hash_word      = r_h[i_cmd.word_idx];

endmodule

`default_nettype wire

@@ rtl/sha_ctrl.sv @@
// Controller of the SHA-256 stream hasher: sequences byte intake, padding,
// compression and digest output. Depends on sha_pkg and the defines header.
`default_nettype none
`include "sha256_stream_hasher_defines.svh"

module sha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_has_byte,
    input  wire logic          i_end_msg,
    input  wire logic          i_out_free,
    input  wire sha_pkg::t_sts i_sts,
    output logic               o_in_ready,
    output sha_pkg::t_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ROUND  = 3'd1;
    localparam logic [2:0] S_FOLD   = 3'd2;
    localparam logic [2:0] S_PAD80  = 3'd3;
    localparam logic [2:0] S_PADZ   = 3'd4;
    localparam logic [2:0] S_PADLEN = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_ret, n_ret;       // state to resume after a non-final fold
    logic       r_final, n_final;   // current compression closes the message
    logic [2:0] r_widx, n_widx;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_final    = r_final;
        n_widx     = r_widx;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_has_byte) begin
                        o_cmd.wr_byte   = 1'b1;
                        o_cmd.byte_kind = sha_pkg::BYTE_DATA;
                        o_cmd.count_inc = 1'b1;
                    end
                    if (i_has_byte && i_sts.pos_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ROUND;
                        n_final     = 1'b0;
                        n_ret       = i_end_msg ? S_PAD80 : S_IDLE;
                    end else if (i_end_msg) begin
                        n_state = S_PAD80;
                    end
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_last) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_final) begin
                    n_state = S_OUT;
                    n_widx  = '0;
                end else begin
                    n_state = r_ret;
                end
            end
            S_PAD80: begin
                o_cmd.wr_byte   = 1'b1;
                o_cmd.byte_kind = sha_pkg::BYTE_80;
                n_state         = S_PADZ;
                if (i_sts.pos_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_ROUND;
                    n_final     = 1'b0;
                    n_ret       = S_PADZ;
                end
            end
            S_PADZ: begin
                if (i_sts.pos_56) begin
                    n_state = S_PADLEN;
                end else begin
                    o_cmd.wr_byte   = 1'b1;
                    o_cmd.byte_kind = sha_pkg::BYTE_ZERO;
                    if (i_sts.pos_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ROUND;
                        n_final     = 1'b0;
                        n_ret       = S_PADZ;
                    end
                end
            end
            S_PADLEN: begin
                o_cmd.wr_byte   = 1'b1;
                o_cmd.byte_kind = sha_pkg::BYTE_LEN;
                if (i_sts.pos_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_ROUND;
                    n_final     = 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.word_idx = r_widx;
                if (i_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_widx         = r_widx + 3'd1;
                    if (r_widx == sha_pkg::LAST_WORD_IDX) begin
                        o_cmd.init = 1'b1;
                        n_final    = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_final <= 1'b0;
            r_widx  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_final <= n_final;
            r_widx  <= n_widx;
        end
    end

    `SHA_ASSERT_NXT(a_round_to_fold, i_clk, i_rst_n, (r_state == S_ROUND) && i_sts.round_last, r_state == S_FOLD, "compression did not end after 64 rounds")
    `SHA_ASSERT_NXT(a_final_to_out, i_clk, i_rst_n, (r_state == S_FOLD) && r_final, r_state == S_OUT, "final fold not followed by digest output")
    `SHA_ASSERT_NXT(a_len_at_56, i_clk, i_rst_n, (r_state == S_PADZ) && i_sts.pos_56, (r_state == S_PADLEN) && i_sts.pos_56, "length field does not start at byte 56")
    `SHA_ASSERT_IMP(a_no_load_in_idle, i_clk, i_rst_n, o_in_ready, !o_cmd.load_out && !o_cmd.round, "input taken while busy")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for sha256_stream_hasher: streams messages byte by byte
// and checks every digest word against a SHA-256 predictor kept in this file.
// Depends only on the RTL top level; the package is not needed.
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam int unsigned IDLE_PERCENT = 29;
    localparam int unsigned HOLD_AT      = 40;   // accepted items before the long stall
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned CALM_FROM    = 60;   // window of accepted items with no idling
    localparam int unsigned CALM_TO      = 100;
    localparam int unsigned RANDOM_ITEMS = 90;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int         LEN_OFFSET = 56;      // byte where the 64-bit length starts
    localparam int         LAST_BYTE  = 63;
    localparam int         WORD_COUNT = 8;

    localparam logic [31:0] HASH_INIT [WORD_COUNT] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // One input transaction. The pause flag holds the item back until every
    // digest word expected so far has been received.
    typedef struct packed {
        bit         pause;
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tuser;   // [0] has_byte
    logic        i_s_axis_tlast;   // end_of_message
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [31:0] digest_word
    logic [2:0]  o_m_axis_tuser;   // [2:0] word_index
    logic        o_m_axis_tlast;   // last_word

    sha256_stream_hasher uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_msg_item    pending_items [$];
    t_digest_word digest_expect [$];

    // Predictor state: chaining words, the 16-word block and the byte count.
    logic [31:0] chain_words [WORD_COUNT];
    logic [31:0] block_words [16];
    logic [60:0] byte_total;

    int unsigned items_accepted = 0;
    int unsigned cycle_count = 0;
    int unsigned words_checked = 0;
    int unsigned fail_count = 0;
    int unsigned live_items = 0;
    int unsigned message_count = 0;
    logic        in_taken = 1'b0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    logic        calm;

    assign calm = (items_accepted >= CALM_FROM) && (items_accepted < CALM_TO);

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // SHA-256 predictor
    // ------------------------------------------------------------------

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_restart();
        for (int i = 0; i < WORD_COUNT; i++) chain_words[i] = HASH_INIT[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        byte_total = '0;
    endtask

    // Bytes fill each word from the most significant end. The first byte of a
    // word overwrites it, so stale contents never leak into a block.
    task automatic put_block_byte(input int pos, input logic [7:0] b);
        int w;
        w = pos / 4;
        if (pos % 4 == 0) begin
            block_words[w] = {b, 24'h0};
        end else begin
            block_words[w] = block_words[w] | (32'(b) << ((3 - pos % 4) * 8));
        end
    endtask

    task automatic compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++) sched[i] = block_words[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
            s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
            sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (int i = 0; i < 64; i++) begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + sched[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_words[0] += a; chain_words[1] += b; chain_words[2] += c; chain_words[3] += d;
        chain_words[4] += e; chain_words[5] += f; chain_words[6] += g; chain_words[7] += h;
    endtask

    // Takes one accepted transaction; a closing one pads, compresses and
    // queues the eight digest words it must produce.
    task automatic hash_absorb(input t_msg_item it);
        int          pos;
        logic [63:0] bit_len;
        if (it.has_byte) begin
            pos = int'(byte_total[5:0]);
            put_block_byte(pos, it.data_byte);
            byte_total = byte_total + 1'b1;
            if (pos == LAST_BYTE) compress_block();
        end
        if (it.end_of_message) begin
            pos = int'(byte_total[5:0]);
            put_block_byte(pos, PAD_MARK);
            pos++;
            // No room left for the length: finish this block and pad a new one.
            if (pos > LEN_OFFSET) begin
                while (pos <= LAST_BYTE) begin
                    put_block_byte(pos, 8'h00);
                    pos++;
                end
                compress_block();
                pos = 0;
            end
            while (pos < LEN_OFFSET) begin
                put_block_byte(pos, 8'h00);
                pos++;
            end
            bit_len = {byte_total, 3'b000};
            for (int i = 7; i >= 0; i--) begin
                put_block_byte(pos, bit_len[i*8 +: 8]);
                pos++;
            end
            compress_block();
            for (int i = 0; i < WORD_COUNT; i++) begin
                digest_expect.push_back('{word: chain_words[i], index: 3'(i),
                                          last: (i == WORD_COUNT - 1)});
            end
            hash_restart();
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    task automatic add_item(input logic [7:0] data, input logic has, input logic eom,
                            input bit pause);
        pending_items.push_back('{pause: pause, data_byte: data, has_byte: has,
                                  end_of_message: eom});
        if (has || eom) live_items++;
    endtask

    // A message of len bytes with random content. Ignored items are sprinkled
    // in as noise, and the close is either on the last byte or a separate
    // empty marker.
    task automatic queue_message(input int len, input bit pause);
        bit hold_back;
        bit close_on_byte;
        hold_back = pause;
        close_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
                add_item(8'($urandom_range(255)), 1'b0, 1'b0, hold_back);
                hold_back = 1'b0;
            end
            add_item(8'($urandom_range(255)), 1'b1, close_on_byte && (k == len - 1), hold_back);
            hold_back = 1'b0;
        end
        if (!close_on_byte) add_item(8'($urandom_range(255)), 1'b0, 1'b1, hold_back);
        message_count++;
    endtask

    // ------------------------------------------------------------------
    // Input side: acceptance at the rising edge, driving at the falling edge.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            hash_absorb(pending_items[0]);
            items_accepted <= items_accepted + 1;
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin : drive_input
        logic offer;
        offer = i_s_axis_tvalid;
        if (in_taken) begin
            pending_items.delete(0);
            offer = 1'b0;
        end
        // Once offered, an item stays valid until it is taken.
        if (i_rst_n && !offer && pending_items.size() != 0) begin
            if (!(pending_items[0].pause && digest_expect.size() != 0) &&
                (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                offer = 1'b1;
            end
        end
        i_s_axis_tvalid <= offer;
        if (offer) begin
            i_s_axis_tdata <= pending_items[0].data_byte;
            i_s_axis_tuser <= pending_items[0].has_byte;
            i_s_axis_tlast <= pending_items[0].end_of_message;
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready with random gaps plus one long hold-off, during
    // which the sender keeps offering so the block backs up.
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : check_digest
        t_digest_word want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (digest_expect.size() == 0) begin
                $display("%0t: unexpected digest word: expected none, got word %h index %0d last %b",
                         $time, o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
                fail_count++;
            end else begin
                want = digest_expect.pop_front();
                words_checked++;
                if (o_m_axis_tdata !== want.word) begin
                    $display("%0t: digest word mismatch: expected %h, got %h",
                             $time, want.word, o_m_axis_tdata);
                    fail_count++;
                end
                if (o_m_axis_tuser !== want.index) begin
                    $display("%0t: word index mismatch: expected %0d, got %0d",
                             $time, want.index, o_m_axis_tuser);
                    fail_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $display("%0t: last word flag mismatch: expected %b, got %b",
                             $time, want.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d items and %0d digest words outstanding",
                     $time, pending_items.size(), digest_expect.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build the stimulus, reset, wait for the traffic to drain.
    // ------------------------------------------------------------------

    initial begin
        int unsigned random_start;
        int          boundary_lens [$];
        int          len;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_s_axis_tlast = 1'b0;
        i_m_axis_tready = 1'b0;
        hash_restart();

        // Directed part.
        add_item(8'h00, 1'b0, 1'b1, 1'b0);          // empty message via empty marker
        add_item(8'ha5, 1'b0, 1'b0, 1'b0);          // idle item, data ignored
        add_item(8'h00, 1'b1, 1'b1, 1'b0);          // single zero byte closing the message
        add_item(8'hff, 1'b1, 1'b0, 1'b0);          // top-bit bytes must not sign-extend
        add_item(8'h80, 1'b1, 1'b0, 1'b0);
        add_item(8'h5a, 1'b0, 1'b1, 1'b0);          // close with empty marker, data ignored
        add_item(8'h61, 1'b1, 1'b0, 1'b1);          // "abc", starting after a full drain
        add_item(8'h62, 1'b1, 1'b0, 1'b0);
        add_item(8'h63, 1'b1, 1'b1, 1'b0);
        add_item(8'h7f, 1'b1, 1'b1, 1'b0);
        message_count += 5;

        // Random part. A length of 63 puts the pad mark in the last byte of a
        // block, so the length field needs an extra block; the longer random
        // lengths reach the other padding edges now and then.
        boundary_lens = '{63};
        random_start = live_items;
        for (int m = 0; (live_items - random_start < RANDOM_ITEMS) || boundary_lens.size() != 0;
             m++) begin
            if (m % 3 == 2 && boundary_lens.size() != 0) begin
                len = boundary_lens.pop_front();
            end else if ($urandom_range(99) < 15) begin
                len = $urandom_range(70, 13);
            end else begin
                len = $urandom_range(12);
            end
            queue_message(len, m % 4 == 0);
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || digest_expect.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d messages over %0d accepted items, including empty and padding-edge",
                 message_count, items_accepted);
        $display("lengths, and checked %0d digest words under random and long output stalls.",
                 words_checked);
        if (fail_count == 0 && digest_expect.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
